// ===== rtl/core/mfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the marker frame parser: buffer depth default,
// parse mode codes, raw header codes and register reset values. No dependencies.
package mfp_pkg;

  localparam int unsigned BufDepthDef = 64;

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeText = 2'd1;
  localparam logic [1:0] ModeRaw  = 2'd2;

  localparam logic [7:0] RawCodeLo = 8'h11;
  localparam logic [7:0] RawCodeHi = 8'h14;
  localparam int unsigned HeaderLen = 3;

  localparam logic [7:0] StartMarkerRst = 8'd60;
  localparam logic [7:0] EndMarkerRst   = 8'd62;

  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgEndMarker   = 1'b1;

  localparam logic KindText = 1'b0;
  localparam logic KindRaw  = 1'b1;

endpackage

// ===== rtl/core/marker_frame_parser.sv =====
`timescale 1ns / 1ps
// Marker frame parser top level: byte deframer with frame store memory.
// Depends on mfp_pkg.
//
// Usage:
//   s_axis carries one received byte per request in tdata. Bytes are taken
//   one per cycle while no frame is being read out of the store.
//   m_axis returns the bytes of each completed frame in stored order; tuser
//   is the frame kind (0 text, 1 raw) and tlast marks the final byte.
//   cfg_* writes start_marker (index 0) or end_marker (index 1).
// Drain:
//   After the closing request the drain state is registered, then each byte
//   is read from the frame store into a read register and moved into a
//   single output register. A new read waits for the previous byte to reach
//   the output register and for the output to be empty or accepted. While a
//   frame drains s_axis_tready is low; it rises once the last read is issued.
// Reset:
//   Clears mode, fill count, drain control and the output valid; markers
//   return to 60 and 62. The frame store is not cleared.
// Stall:
//   A low m_axis_tready holds the output register and pauses the drain,
//   which in turn keeps the input side stalled.
module marker_frame_parser #(
  parameter int unsigned BUF_DEPTH = mfp_pkg::BufDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] frame_kind
  output logic       m_axis_tlast
);
  import mfp_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam logic [AW-1:0] LastPos = AW'(BUF_DEPTH - 2);
  localparam logic [AW-1:0] HdrCnt  = AW'(HeaderLen);
  localparam logic [AW-1:0] Pos1    = AW'(1);
  localparam logic [AW-1:0] Pos2    = AW'(2);
  localparam logic [8:0]    DepthW  = 9'(BUF_DEPTH);

  localparam logic StRun   = 1'b0;
  localparam logic StDrain = 1'b1;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] mem_rd_q;

  logic [7:0]    start_q, end_q;
  logic [1:0]    mode_q, mode_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [7:0]    hdr1_q, hdr1_d;
  logic [7:0]    len_q, len_d;
  logic          st_q, st_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          kind_q, kind_d;
  logic          rd_pend_q, rd_last_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_kind_q, out_last_q;

  logic          in_acc, wr_en, rd_issue, rd_last, raw_entry;
  logic [AW-1:0] wr_addr, base, pos, pos_inc, raw_inc;
  logic [7:0]    c;

  assign c        = s_axis_tdata;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign rd_last  = (rd_ptr_q == cnt_q - AW'(1));
  assign rd_issue = (st_q == StDrain) && !rd_pend_q && (!out_valid_q || m_axis_tready);

  assign base    = (c == start_q) ? '0 : fill_q;
  assign pos     = (base > LastPos) ? LastPos : base;
  assign pos_inc = pos + AW'(1);
  assign raw_inc = fill_q + AW'(1);

  always_comb begin
    mode_d    = mode_q;
    fill_d    = fill_q;
    hdr1_d    = hdr1_q;
    len_d     = len_q;
    st_d      = st_q;
    rd_ptr_d  = rd_ptr_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    wr_en     = 1'b0;
    wr_addr   = pos;
    raw_entry = 1'b0;
    if (in_acc) begin
      if (mode_q == ModeRaw) begin
        if ({1'b0, len_q} >= DepthW) begin
          mode_d = ModeIdle;
        end else begin
          wr_en   = 1'b1;
          wr_addr = fill_q;
          fill_d  = raw_inc;
          if ({{(9-AW){1'b0}}, raw_inc} >= {1'b0, len_q}) begin
            mode_d   = ModeIdle;
            st_d     = StDrain;
            rd_ptr_d = '0;
            cnt_d    = raw_inc;
            kind_d   = KindRaw;
          end
        end
      end else if ((mode_q == ModeText) || (c == start_q)) begin
        wr_en  = 1'b1;
        mode_d = ModeText;
        fill_d = pos_inc;
        if (pos == Pos1) hdr1_d = c;
        if (pos == Pos2) len_d = c;
        raw_entry = (pos_inc == HdrCnt) && (hdr1_q >= RawCodeLo) && (hdr1_q <= RawCodeHi);
        if (raw_entry) begin
          mode_d = ModeRaw;
        end else if (c == end_q) begin
          mode_d   = ModeIdle;
          st_d     = StDrain;
          rd_ptr_d = '0;
          cnt_d    = pos_inc;
          kind_d   = KindText;
        end
      end else begin
        mode_d = ModeIdle;
      end
    end
    if (rd_issue) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
      if (rd_last) st_d = StRun;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      mem_rd_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    hdr1_q <= hdr1_d;
    len_q  <= len_d;
    if (rd_issue) rd_last_q <= rd_last;
    if (rd_pend_q) begin
      out_byte_q <= mem_rd_q;
      out_kind_q <= kind_q;
      out_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= StartMarkerRst;
      end_q       <= EndMarkerRst;
      mode_q      <= ModeIdle;
      fill_q      <= '0;
      st_q        <= StRun;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      kind_q      <= KindText;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgStartMarker: start_q <= cfg_data_i;
          CfgEndMarker:   end_q   <= cfg_data_i;
          default:        ;
        endcase
      end
      mode_q    <= mode_d;
      fill_q    <= fill_d;
      st_q      <= st_d;
      rd_ptr_q  <= rd_ptr_d;
      cnt_q     <= cnt_d;
      kind_q    <= kind_d;
      rd_pend_q <= rd_issue;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (st_q == StRun);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
